// File: design/tfpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thrust force to pulse width: shared definitions
// Widths, fixed-point constants, polynomial coefficient tables and the
// pipeline payload types used by all stages of the converter.
// ----------------------------------------------------------------------------
package tfpw_pkg;

  localparam int FORCE_FRAC_BITS = 8;
  localparam int FORCE_W         = 16;
  localparam int FWD_W           = 15;
  localparam int DBW_W           = 13;
  localparam int PULSE_W         = 12;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  // Coefficients and the curve value are Q16.
  localparam int Q_FRAC   = 16;
  localparam int ACC_W    = 40;
  localparam int POLY_DEG = 7;

  // Kilogram-force conversion: f = trunc(m * 25 * 2^(18 - FORCE_FRAC_BITS) / 981),
  // done as a multiply by a rounded-up reciprocal that is exact for 16-bit m.
  localparam int     KGF_W      = 29 - FORCE_FRAC_BITS;
  localparam int     KGF_SHIFT  = 26 + FORCE_FRAC_BITS;
  localparam longint KGF_MULT   = ((64'sd25 <<< 44) + 64'sd980) / 64'sd981;
  localparam int     KGF_MULT_W = $clog2(KGF_MULT + 1);

  // Any deadband quotient at or above 2^QS_W drives the pulse past the limit on its side.
  localparam int QS_W       = 29;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (QS_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_QW     = DIV_STAGES * DIV_STEP;
  localparam int REM_W      = DBW_W + 1;
  localparam int DLT_W      = ACC_W - 1;
  localparam int PROD_W     = DBW_W + DLT_W;
  localparam int PLS_W      = ACC_W - Q_FRAC;

  localparam int LATENCY = 2 + POLY_DEG + 2 + DIV_STAGES + 1;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t CENTER    = acc_t'(longint'(1500) <<< Q_FRAC);
  localparam acc_t ACC_LIMIT = acc_t'(longint'(1) <<< 38);

  localparam acc_t POS_COEF [POLY_DEG+1] = '{
    40'sd100264073, 40'sd12659751, -40'sd10635100, 40'sd9817798,
    -40'sd5274207, 40'sd1550696, -40'sd233041, 40'sd14024
  };
  localparam acc_t NEG_COEF [POLY_DEG+1] = '{
    40'sd96344760, 40'sd15728626, 40'sd16846536, 40'sd20403954,
    40'sd14380720, 40'sd5544103, 40'sd1091517, 40'sd85962
  };

  localparam logic [FWD_W-1:0]          FWD_RST  = 15'd10216;
  localparam logic signed [FORCE_W-1:0] BWD_RST  = -16'sd7956;
  localparam logic [DBW_W-1:0]          DBW_RST  = 13'd512;
  localparam logic [PULSE_W-1:0]        PMIN_RST = 12'd1100;
  localparam logic [PULSE_W-1:0]        PMAX_RST = 12'd1900;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_FWD   = 3'd0,
    REG_MAX_BWD   = 3'd1,
    REG_DEADBAND  = 3'd2,
    REG_PULSE_MIN = 3'd3,
    REG_PULSE_MAX = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [FWD_W-1:0]          max_fwd;
    logic signed [FORCE_W-1:0] max_bwd;
    logic [DBW_W-1:0]          dbw;
    logic [PULSE_W-1:0]        pmin;
    logic [PULSE_W-1:0]        pmax;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic limited;
    logic db;
    logic xzero;
  } tag_t;

  typedef struct packed {
    tag_t                    tag;
    logic                    neg;
    logic signed [KGF_W-1:0] f;
    logic [DBW_W-1:0]        dmag;
    acc_t                    acc;
  } hpipe_t;

  typedef struct packed {
    tag_t              tag;
    logic              qneg;
    logic              sat;
    logic [REM_W-1:0]  rem;
    logic [DIV_QW-1:0] low;
    logic [DIV_QW-1:0] quo;
    acc_t              pwm;
  } dpipe_t;

endpackage

// File: design/tfpw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end: force clamp and kilogram-force conversion
// Clamps the force to the configured limits, flags limiting and deadband use,
// then converts the curve operand to Q16 kilogram-force in a second stage.
// ----------------------------------------------------------------------------
module tfpw_front import tfpw_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic signed [FORCE_W-1:0] force_i,
  input  cfg_t                      cfg_i,
  output hpipe_t                    pipe_o
);

  localparam int MP_W = FORCE_W + KGF_MULT_W;

  tag_t               a_tag_d, a_tag_q;
  logic               a_neg_d, a_neg_q;
  logic [FORCE_W-1:0] a_mag_d, a_mag_q;
  hpipe_t             b_d, b_q;

  always_comb begin
    logic signed [FORCE_W:0] fz, fwd, bwd, x1, x2;
    fz  = {force_i[FORCE_W-1], force_i};
    fwd = {2'b00, cfg_i.max_fwd};
    bwd = {cfg_i.max_bwd[FORCE_W-1], cfg_i.max_bwd};
    x1  = (fz > fwd) ? fwd : fz;
    x2  = (x1 < bwd) ? bwd : x1;
    a_mag_d = x2[FORCE_W] ? FORCE_W'(-x2) : x2[FORCE_W-1:0];
    a_neg_d = x2[FORCE_W];
    a_tag_d.valid   = valid_i;
    a_tag_d.limited = (x2 != fz);
    a_tag_d.db      = (a_mag_d <= FORCE_W'(cfg_i.dbw));
    a_tag_d.xzero   = (x2 == '0);
  end

  always_comb begin
    logic [FORCE_W-1:0]   m;
    logic [MP_W-1:0]      prod;
    logic [KGF_W-2:0]     fmag;
    logic signed [KGF_W-1:0] fpos;
    m    = a_tag_q.db ? FORCE_W'(cfg_i.dbw) : a_mag_q;
    prod = MP_W'(m) * MP_W'(KGF_MULT);
    fmag = prod[KGF_SHIFT +: KGF_W-1];
    fpos = $signed({1'b0, fmag});
    b_d.tag  = a_tag_q;
    b_d.neg  = a_neg_q;
    b_d.f    = a_neg_q ? -fpos : fpos;
    b_d.dmag = a_mag_q[DBW_W-1:0];
    b_d.acc  = a_neg_q ? NEG_COEF[POLY_DEG] : POS_COEF[POLY_DEG];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tag_q <= '0;
      a_neg_q <= 1'b0;
      a_mag_q <= '0;
      b_q     <= '0;
    end else begin
      a_tag_q <= a_tag_d;
      a_neg_q <= a_neg_d;
      a_mag_q <= a_mag_d;
      b_q     <= b_d;
    end
  end

  assign pipe_o = b_q;

endmodule

// File: design/tfpw_horner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Horner step
// One registered step of the curve: acc = sat(trunc0(acc * f / 2^16) + c),
// with the coefficient picked by the sign of the force.
// ----------------------------------------------------------------------------
module tfpw_horner import tfpw_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  hpipe_t pipe_i,
  input  acc_t   coef_pos_i,
  input  acc_t   coef_neg_i,
  output hpipe_t pipe_o
);

  localparam int AMAG_W = ACC_W - 1;
  localparam int FMAG_W = KGF_W - 1;
  localparam int MP_W   = AMAG_W + FMAG_W;
  localparam int PQ_W   = MP_W - Q_FRAC;
  localparam int SUM_W  = PQ_W + 2;

  hpipe_t pipe_d, pipe_q;

  always_comb begin
    logic [AMAG_W-1:0]       amag;
    logic [FMAG_W-1:0]       fmag;
    logic [MP_W-1:0]         mp;
    logic signed [SUM_W-1:0] ps, sum, lim;
    acc_t                    coef;
    amag = pipe_i.acc[ACC_W-1] ? AMAG_W'(-pipe_i.acc) : AMAG_W'(pipe_i.acc);
    fmag = pipe_i.f[KGF_W-1] ? FMAG_W'(-pipe_i.f) : FMAG_W'(pipe_i.f);
    mp   = MP_W'(amag) * MP_W'(fmag);
    ps   = $signed({2'b00, mp[MP_W-1:Q_FRAC]});
    if (pipe_i.acc[ACC_W-1] ^ pipe_i.f[KGF_W-1]) begin
      ps = -ps;
    end
    coef = pipe_i.neg ? coef_neg_i : coef_pos_i;
    sum  = ps + $signed({{(SUM_W-ACC_W){coef[ACC_W-1]}}, coef});
    lim  = $signed({{(SUM_W-ACC_W){1'b0}}, ACC_LIMIT});
    pipe_d = pipe_i;
    if (sum > lim) begin
      pipe_d.acc = ACC_LIMIT;
    end else if (sum < -lim) begin
      pipe_d.acc = -ACC_LIMIT;
    end else begin
      pipe_d.acc = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q <= '0;
    end else begin
      pipe_q <= pipe_d;
    end
  end

  assign pipe_o = pipe_q;

endmodule

// File: design/tfpw_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider step
// Registered slice of the restoring divider for the deadband interpolation,
// producing a few quotient bits per stage.
// ----------------------------------------------------------------------------
module tfpw_div_step import tfpw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dpipe_t           pipe_i,
  input  logic [DBW_W-1:0] dbw_i,
  output dpipe_t           pipe_o
);

  dpipe_t pipe_d, pipe_q;

  always_comb begin
    logic [REM_W-1:0]  r;
    logic [DIV_QW-1:0] lo, qo;
    r  = pipe_i.rem;
    lo = pipe_i.low;
    qo = pipe_i.quo;
    for (int j = 0; j < DIV_STEP; j++) begin
      r  = {r[REM_W-2:0], lo[DIV_QW-1]};
      lo = {lo[DIV_QW-2:0], 1'b0};
      if (r >= {1'b0, dbw_i}) begin
        r  = r - {1'b0, dbw_i};
        qo = {qo[DIV_QW-2:0], 1'b1};
      end else begin
        qo = {qo[DIV_QW-2:0], 1'b0};
      end
    end
    pipe_d     = pipe_i;
    pipe_d.rem = r;
    pipe_d.low = lo;
    pipe_d.quo = qo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q <= '0;
    end else begin
      pipe_q <= pipe_d;
    end
  end

  assign pipe_o = pipe_q;

endmodule

// File: design/tfpw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadband interpolation divider
// Forms |force| * |curve edge - center|, checks it against the saturation
// point and divides it by the deadband width in a chain of divider steps.
// ----------------------------------------------------------------------------
module tfpw_div import tfpw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hpipe_t           pipe_i,
  input  logic [DBW_W-1:0] dbw_i,
  output dpipe_t           pipe_o
);

  localparam int SC_W = PROD_W - QS_W;

  tag_t              p_tag_q;
  logic              p_neg_d, p_neg_q;
  logic [PROD_W-1:0] p_prod_d, p_prod_q;
  acc_t              p_pwm_q;
  dpipe_t            s_d, s_q;
  dpipe_t            stg [DIV_STAGES+1];

  always_comb begin
    logic signed [ACC_W:0] dl;
    logic [DLT_W-1:0]      dlm;
    dl       = {pipe_i.acc[ACC_W-1], pipe_i.acc} - {CENTER[ACC_W-1], CENTER};
    dlm      = dl[ACC_W] ? DLT_W'(-dl) : DLT_W'(dl);
    p_neg_d  = dl[ACC_W];
    p_prod_d = PROD_W'(pipe_i.dmag) * PROD_W'(dlm);
  end

  always_comb begin
    s_d.tag  = p_tag_q;
    s_d.qneg = p_neg_q;
    s_d.sat  = (p_prod_q[PROD_W-1:QS_W] >= SC_W'(dbw_i));
    s_d.rem  = p_prod_q[DIV_QW +: REM_W];
    s_d.low  = p_prod_q[DIV_QW-1:0];
    s_d.quo  = '0;
    s_d.pwm  = p_pwm_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_tag_q  <= '0;
      p_neg_q  <= 1'b0;
      p_prod_q <= '0;
      p_pwm_q  <= '0;
      s_q      <= '0;
    end else begin
      p_tag_q  <= pipe_i.tag;
      p_neg_q  <= p_neg_d;
      p_prod_q <= p_prod_d;
      p_pwm_q  <= pipe_i.acc;
      s_q      <= s_d;
    end
  end

  assign stg[0] = s_q;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_step
    tfpw_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pipe_i (stg[s]),
      .dbw_i  (dbw_i),
      .pipe_o (stg[s+1])
    );
  end

  assign pipe_o = stg[DIV_STAGES];

endmodule

// File: design/thrust_force_to_pulse_width.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thrust force to ESC pulse width
// Stages from start to done_o: 2 front, 7 Horner, 2 product and check,
//   8 divider and 1 output stage.
// Throughput: one transaction per cycle; busy stays low and results cannot
//   be stalled. Reset clears the pipeline and loads the default registers.
// ----------------------------------------------------------------------------
module thrust_force_to_pulse_width import tfpw_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [FORCE_W-1:0] thrust_force_i,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  output logic                      done_o,
  output logic [PULSE_W-1:0]        pulse_us_o,
  output logic                      force_limited_o,
  output logic                      in_deadband_o
);

  cfg_t               cfg_d, cfg_q;
  hpipe_t             hp [POLY_DEG+1];
  dpipe_t             dp;
  logic               done_d, done_q;
  logic [PULSE_W-1:0] pulse_d, pulse_q;
  logic               lim_q, db_q;

  assign busy = 1'b0;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_MAX_FWD:   cfg_d.max_fwd = cfg_data_i[FWD_W-1:0];
        REG_MAX_BWD:   cfg_d.max_bwd = $signed(cfg_data_i[FORCE_W-1:0]);
        REG_DEADBAND:  cfg_d.dbw     = cfg_data_i[DBW_W-1:0];
        REG_PULSE_MIN: cfg_d.pmin    = cfg_data_i[PULSE_W-1:0];
        REG_PULSE_MAX: cfg_d.pmax    = cfg_data_i[PULSE_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  tfpw_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .force_i (thrust_force_i),
    .cfg_i   (cfg_q),
    .pipe_o  (hp[0])
  );

  for (genvar k = 0; k < POLY_DEG; k++) begin : g_horner
    tfpw_horner u_horner (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .pipe_i     (hp[k]),
      .coef_pos_i (POS_COEF[POLY_DEG-1-k]),
      .coef_neg_i (NEG_COEF[POLY_DEG-1-k]),
      .pipe_o     (hp[k+1])
    );
  end

  tfpw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pipe_i (hp[POLY_DEG]),
    .dbw_i  (cfg_q.dbw),
    .pipe_o (dp)
  );

  always_comb begin
    logic [QS_W:0]             q;
    logic signed [QS_W+1:0]    term;
    acc_t                      pwm_db, pwm, apwm;
    logic signed [PLS_W-1:0]   pls, pmin_s, pmax_s;
    q      = dp.sat ? {1'b1, {QS_W{1'b0}}} : {1'b0, dp.quo[QS_W-1:0]};
    term   = dp.qneg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    pwm_db = CENTER + $signed({{(ACC_W-QS_W-2){term[QS_W+1]}}, term});
    if (dp.tag.xzero) begin
      pwm = CENTER;
    end else if (dp.tag.db) begin
      pwm = pwm_db;
    end else begin
      pwm = dp.pwm;
    end
    apwm   = pwm[ACC_W-1] ? -pwm : pwm;
    pls    = $signed({1'b0, apwm[ACC_W-2:Q_FRAC]});
    if (pwm[ACC_W-1]) begin
      pls = -pls;
    end
    pmin_s = $signed({{(PLS_W-PULSE_W){1'b0}}, cfg_q.pmin});
    pmax_s = $signed({{(PLS_W-PULSE_W){1'b0}}, cfg_q.pmax});
    if (pls < pmin_s) begin
      pulse_d = cfg_q.pmin;
    end else if (pls > pmax_s) begin
      pulse_d = cfg_q.pmax;
    end else begin
      pulse_d = pls[PULSE_W-1:0];
    end
    done_d = dp.tag.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '{max_fwd: FWD_RST, max_bwd: BWD_RST, dbw: DBW_RST,
                   pmin: PMIN_RST, pmax: PMAX_RST};
      done_q  <= 1'b0;
      pulse_q <= '0;
      lim_q   <= 1'b0;
      db_q    <= 1'b0;
    end else begin
      cfg_q   <= cfg_d;
      done_q  <= done_d;
      pulse_q <= pulse_d;
      lim_q   <= dp.tag.limited;
      db_q    <= dp.tag.db;
    end
  end

  assign done_o          = done_q;
  assign pulse_us_o      = pulse_q;
  assign force_limited_o = lim_q;
  assign in_deadband_o   = db_q;

  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("An accepted transaction did not produce a result in time.");

  a_done_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("A result appeared without a matching accepted transaction.");

  a_pulse_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(cfg_q.pmin) <= $past(cfg_q.pmax))) |->
      (pulse_us_o >= $past(cfg_q.pmin)) && (pulse_us_o <= $past(cfg_q.pmax)))
    else $error("The pulse width lies outside the configured limits.");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thrust force to pulse width testbench
// Drives force commands through the converter under several register
// settings, predicts each pulse width and flag set in 64-bit arithmetic,
// and compares every result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import tfpw_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int SETTLE   = LATENCY + 10;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse;
    logic               limited;
    logic               db;
  } pulse_res_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [FORCE_W-1:0] thrust_force_i = '0;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i = '0;
  logic                      done_o;
  logic [PULSE_W-1:0]        pulse_us_o;
  logic                      force_limited_o;
  logic                      in_deadband_o;

  thrust_force_to_pulse_width dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  longint fwd_lim, bwd_lim, db_width, pls_min, pls_max;
  logic [FORCE_W-1:0] force_queue[$];
  pulse_res_t         pulse_queue[$];
  int                 errors = 0;
  int                 idle_cycles = 0;
  int                 gap = 0;

  function automatic longint sat38(longint v);
    if (v > (64'sd1 <<< 38)) return 64'sd1 <<< 38;
    if (v < -(64'sd1 <<< 38)) return -(64'sd1 <<< 38);
    return v;
  endfunction

  function automatic longint horner(bit neg, longint f);
    longint c[8];
    longint acc, p, ua, uf;
    if (neg) c = '{96344760, 15728626, 16846536, 20403954, 14380720, 5544103, 1091517, 85962};
    else c = '{100264073, 12659751, -10635100, 9817798, -5274207, 1550696, -233041, 14024};
    acc = c[7];
    for (int k = 6; k >= 0; k--) begin
      ua = acc < 0 ? -acc : acc;
      uf = f < 0 ? -f : f;
      p = (ua * uf) >>> 16;
      if ((acc < 0) != (f < 0)) p = -p;
      acc = sat38(p + c[k]);
    end
    return acc;
  endfunction

  function automatic longint kgf(longint x);
    return (x * 6553600) / (64'sd981 <<< FORCE_FRAC_BITS);
  endfunction

  function automatic pulse_res_t predict_pulse(logic signed [FORCE_W-1:0] frc);
    pulse_res_t r;
    longint f, x, mag, pwm, pulse, delta;
    bit db;
    f = frc;
    x = f;
    if (x > fwd_lim) x = fwd_lim;
    if (x < bwd_lim) x = bwd_lim;
    mag = x < 0 ? -x : x;
    db = mag <= db_width;
    pwm = 64'sd1500 <<< 16;
    if (db) begin
      if (db_width != 0) begin
        if (x >= 0) delta = horner(0, kgf(db_width)) - (64'sd1500 <<< 16);
        else delta = (64'sd1500 <<< 16) - horner(1, kgf(-db_width));
        pwm = (64'sd1500 <<< 16) + (x * delta) / db_width;
      end
    end else if (x * 10000 > (64'sd1 <<< FORCE_FRAC_BITS)) begin
      pwm = horner(0, kgf(x));
    end else if (-x * 10000 > (64'sd1 <<< FORCE_FRAC_BITS)) begin
      pwm = horner(1, kgf(x));
    end
    pulse = pwm / 65536;
    if (pulse < pls_min) pulse = pls_min;
    else if (pulse > pls_max) pulse = pls_max;
    r.pulse = pulse[PULSE_W-1:0];
    r.limited = (x != f);
    r.db = db;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        pulse_queue.push_back(predict_pulse(thrust_force_i));
      end
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (force_queue.size() > 0) begin
        thrust_force_i <= force_queue.pop_front();
        start <= 1'b1;
        gap <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pulse_queue.size() == 0) begin
        $display("%0t: unexpected result pulse=%0d", $time, pulse_us_o);
        errors++;
      end else begin
        pulse_res_t e;
        e = pulse_queue.pop_front();
        if (e.pulse !== pulse_us_o || e.limited !== force_limited_o ||
            e.db !== in_deadband_o) begin
          $display("%0t: expected pulse=%0d lim=%0b db=%0b, actual pulse=%0d lim=%0b db=%0b",
                   $time, e.pulse, e.limited, e.db, pulse_us_o, force_limited_o,
                   in_deadband_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("thrust_force_to_pulse_width: mismatch");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MAX_FWD:   fwd_lim = val[14:0];
      REG_MAX_BWD:   bwd_lim = $signed(val);
      REG_DEADBAND:  db_width = val[12:0];
      REG_PULSE_MIN: pls_min = val[11:0];
      REG_PULSE_MAX: pls_max = val[11:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (force_queue.size() > 0 || start || pulse_queue.size() > 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic push_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 3) force_queue.push_back($urandom());
      else if (r < 6) force_queue.push_back($urandom_range(0, 2 * db_width + 2) - db_width - 1);
      else if (r < 9) force_queue.push_back($urandom_range(0, 24000) - 12000);
      else force_queue.push_back($urandom_range(0, 6) - 3);
    end
  endtask

  initial begin
    fwd_lim = FWD_RST;
    bwd_lim = BWD_RST;
    db_width = DBW_RST;
    pls_min = PMIN_RST;
    pls_max = PMAX_RST;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (force_queue[i]) ;
    force_queue = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff, 16'd512,
                    16'd513, -16'sd512, -16'sd513, 16'd10216, 16'd10217,
                    -16'sd7956, -16'sd7957, 16'd2, -16'sd2, 16'd3000, -16'sd3000};
    drain();
    push_random(300);
    drain();

    write_reg(REG_MAX_FWD, 16'h7fff);
    write_reg(REG_MAX_BWD, 16'h8000);
    write_reg(REG_DEADBAND, 16'd1);
    write_reg(REG_PULSE_MIN, 16'd0);
    write_reg(REG_PULSE_MAX, 16'hfff);
    force_queue = '{16'h7fff, 16'h8000, 16'd1, -16'sd1, 16'd0};
    push_random(300);
    drain();

    write_reg(REG_DEADBAND, 16'd0);
    force_queue = '{16'd0, 16'd1, -16'sd1};
    push_random(200);
    drain();

    write_reg(REG_MAX_FWD, 16'd0);
    write_reg(REG_MAX_BWD, 16'd0);
    write_reg(REG_DEADBAND, 16'h1fff);
    force_queue = '{16'h7fff, 16'h8000, 16'd0};
    push_random(100);
    drain();

    write_reg(REG_MAX_FWD, 16'd100);
    write_reg(REG_MAX_BWD, -16'sd50);
    write_reg(REG_DEADBAND, 16'd4096);
    write_reg(REG_PULSE_MIN, 16'd1800);
    write_reg(REG_PULSE_MAX, 16'd1200);
    force_queue = '{16'd200, -16'sd200};
    push_random(150);
    drain();

    for (int s = 0; s < 4; s++) begin
      write_reg(REG_MAX_FWD, $urandom_range(0, 32767));
      write_reg(REG_MAX_BWD, -$urandom_range(0, 32768));
      write_reg(REG_DEADBAND, $urandom_range(1, 4096));
      write_reg(REG_PULSE_MIN, $urandom_range(0, 1500));
      write_reg(REG_PULSE_MAX, $urandom_range(1500, 4095));
      push_random(150);
      drain();
    end

    if (errors == 0) begin
      $display("thrust_force_to_pulse_width: match");
    end else begin
      $display("thrust_force_to_pulse_width: mismatch");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/tfpw_pkg.sv
design/tfpw_front.sv
design/tfpw_horner.sv
design/tfpw_div_step.sv
design/tfpw_div.sv
design/thrust_force_to_pulse_width.sv
tb/tb_top.sv
